[rtl/core/turtle_symbol_interpreter_assert.svh]
// assertion macros for the turtle interpreter checker
`ifndef TURTLE_SYMBOL_INTERPRETER_ASSERT_SVH
`define TURTLE_SYMBOL_INTERPRETER_ASSERT_SVH

// clocked property, switched off while reset is held
`define TSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define TSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tsi_pkg.sv]
// shared types and constants of the turtle symbol interpreter
package tsi_pkg;

  // character codes that act
  localparam logic [7:0] SYM_FWD   = 8'h46;
  localparam logic [7:0] SYM_PUSH  = 8'h5B;
  localparam logic [7:0] SYM_POP   = 8'h5D;
  localparam logic [7:0] SYM_LEFT  = 8'h2B;
  localparam logic [7:0] SYM_RIGHT = 8'h2D;

  // register indexes
  localparam logic [1:0] REG_COS   = 2'd0;
  localparam logic [1:0] REG_SIN   = 2'd1;
  localparam logic [1:0] REG_DIR_X = 2'd2;
  localparam logic [1:0] REG_DIR_Y = 2'd3;

  // register reset values
  localparam logic signed [15:0] COS_RESET   = 16'sd16384;
  localparam logic signed [15:0] SIN_RESET   = 16'sd0;
  localparam logic signed [31:0] DIR_X_RESET = 32'sd0;
  localparam logic signed [31:0] DIR_Y_RESET = 32'sd6554;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FWD,
    OP_PUSH,
    OP_POP,
    OP_LEFT,
    OP_RIGHT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY_POP = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

  // classified request between front and back
  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [31:0] start_dir_x;
    logic signed [31:0] start_dir_y;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } turtle_t;

  typedef struct packed {
    logic               segment_valid;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] bound_left;
    logic        [30:0] bound_right;
    logic signed [31:0] bound_down;
    logic        [30:0] bound_up;
    status_t            status;
  } res_t;

endpackage

[rtl/core/tsi_fifo.sv]
// two-entry queue
module tsi_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] data_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_wr, do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = data_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/tsi_front.sv]
// front end: accepts symbols, classifies them and queues the requests
module tsi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    symbol,
  input  logic          start_req,
  output logic          full,
  input  logic          cmd_pop,
  output tsi_pkg::cmd_t cmd,
  output logic          cmd_empty
);

  tsi_pkg::cmd_t cls;
  logic [$bits(tsi_pkg::cmd_t)-1:0] q_rd;

  // symbol decode
  always_comb begin
    cls.start = start_req;
    case (symbol)
      tsi_pkg::SYM_FWD:   cls.op = tsi_pkg::OP_FWD;
      tsi_pkg::SYM_PUSH:  cls.op = tsi_pkg::OP_PUSH;
      tsi_pkg::SYM_POP:   cls.op = tsi_pkg::OP_POP;
      tsi_pkg::SYM_LEFT:  cls.op = tsi_pkg::OP_LEFT;
      tsi_pkg::SYM_RIGHT: cls.op = tsi_pkg::OP_RIGHT;
      default:            cls.op = tsi_pkg::OP_NONE;
    endcase
  end

  // queue towards the back end
  tsi_fifo #(
    .W($bits(tsi_pkg::cmd_t))
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(q_rd),
    .empty  (cmd_empty)
  );

  assign cmd = tsi_pkg::cmd_t'(q_rd);

endmodule

[rtl/core/tsi_exec.sv]
// back end: turtle state, save stack, rotation and bounding box
module tsi_exec #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tsi_pkg::cfg_t cfg,
  input  tsi_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output tsi_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int MD = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  tsi_pkg::turtle_t   cur_r, cur_nxt, eff;
  tsi_pkg::turtle_t   top_r, below_r;
  tsi_pkg::turtle_t   mem [MD];
  logic [LW-1:0]      level_r, level_nxt, eff_level, lvl_m1, lvl_m3;
  logic signed [31:0] left_r, left_nxt, eff_left;
  logic signed [31:0] down_r, down_nxt, eff_down;
  logic [30:0]        right_r, right_nxt, eff_right;
  logic [30:0]        up_r, up_nxt, eff_up;
  logic               go, do_push, do_pop, stk_full;
  logic signed [32:0] sum_x, sum_y;
  logic signed [31:0] to_x, to_y;
  logic               hit;
  logic signed [16:0] c17, s17;
  logic signed [48:0] p_cx, p_cy, p_sx, p_sy;
  logic signed [49:0] rx_full, ry_full, rx_sh, ry_sh;
  logic signed [31:0] rot_x, rot_y;
  logic [AW-1:0]      wa, ra;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  // state as seen after an optional start request
  always_comb begin
    if (cmd.start) begin
      eff.px    = '0;
      eff.py    = '0;
      eff.dx    = cfg.start_dir_x;
      eff.dy    = cfg.start_dir_y;
      eff_level = '0;
      eff_left  = '0;
      eff_right = '0;
      eff_down  = '0;
      eff_up    = '0;
    end else begin
      eff       = cur_r;
      eff_level = level_r;
      eff_left  = left_r;
      eff_right = right_r;
      eff_down  = down_r;
      eff_up    = up_r;
    end
  end

  // forward step with saturation
  always_comb begin
    sum_x = $signed({eff.px[31], eff.px}) + $signed({eff.dx[31], eff.dx});
    sum_y = $signed({eff.py[31], eff.py}) + $signed({eff.dy[31], eff.dy});
    to_x  = sat32(36'(sum_x));
    to_y  = sat32(36'(sum_y));
    hit   = (33'(to_x) != sum_x) || (33'(to_y) != sum_y);
  end

  // rotation, rounded half up in Q2.14
  always_comb begin
    c17     = 17'(cfg.cos_angle);
    s17     = (cmd.op == tsi_pkg::OP_RIGHT) ? -17'(cfg.sin_angle) : 17'(cfg.sin_angle);
    p_cx    = c17 * eff.dx;
    p_cy    = c17 * eff.dy;
    p_sx    = s17 * eff.dx;
    p_sy    = s17 * eff.dy;
    rx_full = 50'(p_cx) - 50'(p_sy) + 50'sd8192;
    ry_full = 50'(p_sx) + 50'(p_cy) + 50'sd8192;
    rx_sh   = rx_full >>> 14;
    ry_sh   = ry_full >>> 14;
    rot_x   = sat32(rx_sh[35:0]);
    rot_y   = sat32(ry_sh[35:0]);
  end

  // stack addressing
  assign stk_full = (eff_level == LW'(STACK_DEPTH));
  assign do_push  = go && (cmd.op == tsi_pkg::OP_PUSH) && !stk_full;
  assign do_pop   = go && (cmd.op == tsi_pkg::OP_POP) && (eff_level != '0);
  assign lvl_m1   = eff_level - LW'(1);
  assign lvl_m3   = eff_level - LW'(3);
  assign wa       = lvl_m1[AW-1:0];
  assign ra       = lvl_m3[AW-1:0];

  // next turtle state and result
  always_comb begin
    cur_nxt   = eff;
    level_nxt = eff_level;
    left_nxt  = eff_left;
    right_nxt = eff_right;
    down_nxt  = eff_down;
    up_nxt    = eff_up;

    res.segment_valid = 1'b0;
    res.from_x        = '0;
    res.from_y        = '0;
    res.to_x          = '0;
    res.to_y          = '0;
    res.status        = tsi_pkg::ST_OK;

    case (cmd.op)
      tsi_pkg::OP_FWD: begin
        cur_nxt.px        = to_x;
        cur_nxt.py        = to_y;
        res.segment_valid = 1'b1;
        res.from_x        = eff.px;
        res.from_y        = eff.py;
        res.to_x          = to_x;
        res.to_y          = to_y;
        if (hit) begin
          res.status = tsi_pkg::ST_SAT;
        end
        if (to_x < eff_left) begin
          left_nxt = to_x;
        end
        if (to_x > $signed({1'b0, eff_right})) begin
          right_nxt = to_x[30:0];
        end
        if (to_y < eff_down) begin
          down_nxt = to_y;
        end
        if (to_y > $signed({1'b0, eff_up})) begin
          up_nxt = to_y[30:0];
        end
      end
      tsi_pkg::OP_PUSH: begin
        if (stk_full) begin
          res.status = tsi_pkg::ST_OVERFLOW;
        end else begin
          level_nxt = eff_level + LW'(1);
        end
      end
      tsi_pkg::OP_POP: begin
        if (eff_level == '0) begin
          res.status = tsi_pkg::ST_EMPTY_POP;
        end else begin
          level_nxt = lvl_m1;
          cur_nxt   = top_r;
        end
      end
      tsi_pkg::OP_LEFT, tsi_pkg::OP_RIGHT: begin
        cur_nxt.dx = rot_x;
        cur_nxt.dy = rot_y;
      end
      default: begin
      end
    endcase

    res.bound_left  = left_nxt;
    res.bound_right = right_nxt;
    res.bound_down  = down_nxt;
    res.bound_up    = up_nxt;
  end

  // turtle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.px <= '0;
      cur_r.py <= '0;
      cur_r.dx <= tsi_pkg::DIR_X_RESET;
      cur_r.dy <= tsi_pkg::DIR_Y_RESET;
      level_r  <= '0;
      left_r   <= '0;
      right_r  <= '0;
      down_r   <= '0;
      up_r     <= '0;
    end else if (go) begin
      cur_r   <= cur_nxt;
      level_r <= level_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      down_r  <= down_nxt;
      up_r    <= up_nxt;
    end
  end

  // top two stack entries held in registers, the rest in memory
  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r   <= eff;
      below_r <= top_r;
    end else if (do_pop) begin
      top_r   <= below_r;
      below_r <= mem[ra];
    end
  end

  // spill of the old top on a push
  always_ff @(posedge clk) begin
    if (do_push && (eff_level != '0)) begin
      mem[wa] <= top_r;
    end
  end

endmodule

[rtl/core/turtle_symbol_interpreter.sv]
// top level of the turtle symbol interpreter
//
// Input channel: a symbol and a start flag are taken at a clock edge with
// push high and full low. F steps the turtle and draws a segment, [ and ]
// save and restore position and direction, + and - turn by the angle held
// in the cos/sin registers. A set start flag restarts turtle, stack and
// bounding box before the symbol is carried out.
// Result channel: one result per symbol, oldest first, shown while empty
// is low and taken at an edge with pop high.
// A result passes the request queue and the combinational back end into
// the result queue; one symbol a cycle is sustained while pop stays high.
// A two-entry queue sits on either side of the back end, so a stalled
// receiver fills the result queue, then the request queue, and full rises.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12;
// the user must write them while no request is in flight; block won't check.
// Reset (rst_n low, synchronous) empties both queues, clears the stack and
// bounds and loads the register defaults; it needs no clearing pass.
module turtle_symbol_interpreter #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_symbol,
  input  logic               in_start_req,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic               out_segment_valid,
  output logic signed [31:0] out_from_x,
  output logic signed [31:0] out_from_y,
  output logic signed [31:0] out_to_x,
  output logic signed [31:0] out_to_y,
  output logic signed [31:0] out_bound_left,
  output logic [30:0]        out_bound_right,
  output logic signed [31:0] out_bound_down,
  output logic [30:0]        out_bound_up,
  output logic [1:0]         out_status,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tsi_pkg::cfg_t cfg_r;
  tsi_pkg::cmd_t cmd;
  tsi_pkg::res_t res_in, res_out;
  logic          cmd_empty, cmd_pop;
  logic          res_push, res_full;
  logic          wr_en;
  logic [$bits(tsi_pkg::res_t)-1:0] res_rd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_angle   <= tsi_pkg::COS_RESET;
      cfg_r.sin_angle   <= tsi_pkg::SIN_RESET;
      cfg_r.start_dir_x <= tsi_pkg::DIR_X_RESET;
      cfg_r.start_dir_y <= tsi_pkg::DIR_Y_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        tsi_pkg::REG_COS:   cfg_r.cos_angle   <= pwdata[15:0];
        tsi_pkg::REG_SIN:   cfg_r.sin_angle   <= pwdata[15:0];
        tsi_pkg::REG_DIR_X: cfg_r.start_dir_x <= pwdata;
        tsi_pkg::REG_DIR_Y: cfg_r.start_dir_y <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      tsi_pkg::REG_COS:   prdata = 32'(cfg_r.cos_angle);
      tsi_pkg::REG_SIN:   prdata = 32'(cfg_r.sin_angle);
      tsi_pkg::REG_DIR_X: prdata = cfg_r.start_dir_x;
      tsi_pkg::REG_DIR_Y: prdata = cfg_r.start_dir_y;
      default:            prdata = '0;
    endcase
  end

  // front end
  tsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .symbol   (in_symbol),
    .start_req(in_start_req),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  // back end
  tsi_exec #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res_in),
    .res_push (res_push),
    .res_full (res_full)
  );

  // result queue
  tsi_fifo #(
    .W($bits(tsi_pkg::res_t))
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_rd),
    .empty  (empty)
  );

  // result fields to ports
  assign res_out           = tsi_pkg::res_t'(res_rd);
  assign out_segment_valid = res_out.segment_valid;
  assign out_from_x        = res_out.from_x;
  assign out_from_y        = res_out.from_y;
  assign out_to_x          = res_out.to_x;
  assign out_to_y          = res_out.to_y;
  assign out_bound_left    = res_out.bound_left;
  assign out_bound_right   = res_out.bound_right;
  assign out_bound_down    = res_out.bound_down;
  assign out_bound_up      = res_out.bound_up;
  assign out_status        = res_out.status;

endmodule

[rtl/core/tsi_checker.sv]
// port-level checker for the turtle symbol interpreter and its bind
`include "turtle_symbol_interpreter_assert.svh"

module tsi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               out_segment_valid,
  input logic signed [31:0] out_from_x,
  input logic signed [31:0] out_from_y,
  input logic signed [31:0] out_to_x,
  input logic signed [31:0] out_to_y,
  input logic signed [31:0] out_bound_left,
  input logic signed [31:0] out_bound_down,
  input logic [1:0]         out_status
);

  // both queues come out of reset empty
  `TSI_ASSERT_RST(a_reset_empty, (!rst_n |=> empty && !full), "queues not empty after reset")

  // a waiting result holds until taken
  `TSI_ASSERT(a_hold, (!empty && !pop |=> !empty && $stable(out_status) && $stable(out_to_x)), "result changed while stalled")

  // no segment means zero end points
  `TSI_ASSERT(a_no_seg_zero, (!empty && !out_segment_valid |-> out_from_x == 0 && out_from_y == 0 && out_to_x == 0 && out_to_y == 0), "end points set without a segment")

  // a drawn segment reports only ok or saturation, and bounds stay on the origin side
  `TSI_ASSERT(a_seg_status, (!empty && out_segment_valid |-> (out_status == tsi_pkg::ST_OK || out_status == tsi_pkg::ST_SAT) && (out_bound_left <= 0) && (out_bound_down <= 0)), "bad status or bounds with a segment")

endmodule

bind turtle_symbol_interpreter tsi_checker u_tsi_checker (.*);
